[hw/rtl/bcsp_pkg.sv]
// Shared types and constants of the block-to-CHS seek planner.
// No dependencies; used by bcsp_ctrl, bcsp_dp and the top level.
package bcsp_pkg;

	// payload widths fixed by the interface
	localparam int BLOCK_W    = 16;
	localparam int SPT_W      = 6;
	localparam int HEADS_W    = 4;
	localparam int LAST_W     = 16;
	localparam int CYL_OUT_W  = 10;
	localparam int HEAD_W     = 3;
	localparam int OUT_DATA_W = 40;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// register map, index = paddr[3:2]
	localparam logic [1:0] REG_SPT   = 2'd0;
	localparam logic [1:0] REG_HEADS = 2'd1;
	localparam logic [1:0] REG_LAST  = 2'd2;

	localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd17;
	localparam logic [HEADS_W-1:0] HEADS_RESET = 4'd4;
	localparam logic [LAST_W-1:0]  LAST_RESET  = 16'd10403;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_SPT,
		ST_DIV_TRK,
		ST_DIV_CYL,
		ST_FINISH
	} bcsp_state_t;

	// which division the shared divider is running
	typedef enum logic [1:0] {
		PH_SPT,
		PH_TRK,
		PH_CYL
	} bcsp_phase_t;

	typedef struct packed {
		logic        load;
		logic        step;
		bcsp_phase_t phase;
		logic        finish;
	} bcsp_cmd_t;

	typedef struct packed {
		logic last;
		logic rej;
		logic out_free;
	} bcsp_status_t;

endpackage

[hw/rtl/block_to_chs_seek_planner_top.sv]
// Top level of the block-to-CHS seek planner: APB register file and wiring
// of bcsp_ctrl and bcsp_dp. Depends on bcsp_pkg, bcsp_ctrl, bcsp_dp.
//
// Each input transaction carries a logical block number. If it exceeds
// last_block (or sectors_per_track or head_count is zero) the result comes
// back with m_tuser low, all data fields zero, and the remembered cylinder
// untouched. Otherwise one shared restoring divider, one quotient bit per
// cycle, runs three divisions: block / sectors_per_track (remainder =
// sector), that quotient / head_count (= track), and track / head_count
// (quotient = cylinder, remainder = head). The result then gives the seek
// step count and direction from the remembered cylinder, which is updated.
// One block is handled at a time: the next block is accepted only after
// the previous one has finished its divisions, or its rejection, and its
// result has entered the output register. The output register lets the
// next block enter while the previous result still waits on m_tready.
module block_to_chs_seek_planner_top #(
	parameter int BLOCK_WIDTH    = 16,
	parameter int CYLINDER_WIDTH = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bcsp_pkg::BLOCK_W-1:0]        s_tdata,   // [15:0] block_number
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [9:0] cylinder, [12:10] head, [18:13] sector, [28:19] step_count,
	// [29] step_outward, [34:30] head_select_code, [39:35] zero
	output logic [bcsp_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                m_tuser,   // [0] in_range
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bcsp_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [bcsp_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [bcsp_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	logic [bcsp_pkg::SPT_W-1:0]   spt_q;
	logic [bcsp_pkg::HEADS_W-1:0] heads_q;
	logic [bcsp_pkg::LAST_W-1:0]  last_q;
	logic                         wr_en;
	logic [1:0]                   reg_idx;

	bcsp_pkg::bcsp_cmd_t    cmd;
	bcsp_pkg::bcsp_status_t status;

	// registers sit at byte addresses 0, 4, 8; zero-wait APB
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q   <= bcsp_pkg::SPT_RESET;
			heads_q <= bcsp_pkg::HEADS_RESET;
			last_q  <= bcsp_pkg::LAST_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				bcsp_pkg::REG_SPT:   spt_q   <= pwdata[bcsp_pkg::SPT_W-1:0];
				bcsp_pkg::REG_HEADS: heads_q <= pwdata[bcsp_pkg::HEADS_W-1:0];
				bcsp_pkg::REG_LAST:  last_q  <= pwdata[bcsp_pkg::LAST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// read-back; unmapped addresses read zero
	always_comb begin
		case (reg_idx)
			bcsp_pkg::REG_SPT:   prdata = bcsp_pkg::APB_DATA_W'(spt_q);
			bcsp_pkg::REG_HEADS: prdata = bcsp_pkg::APB_DATA_W'(heads_q);
			bcsp_pkg::REG_LAST:  prdata = bcsp_pkg::APB_DATA_W'(last_q);
			default:             prdata = '0;
		endcase
	end

	bcsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bcsp_dp #(
		.BLOCK_WIDTH    (BLOCK_WIDTH),
		.CYLINDER_WIDTH (CYLINDER_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.block_in (s_tdata),
		.spt      (spt_q),
		.heads    (heads_q),
		.last_blk (last_q),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

[hw/rtl/bcsp_ctrl.sv]
// Sequencer of the seek planner: accept, three divisions (skipped for a rejected block), result hand-off.
// Depends on bcsp_pkg.
module bcsp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  bcsp_pkg::bcsp_status_t status,
	output bcsp_pkg::bcsp_cmd_t    cmd
);

	bcsp_pkg::bcsp_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcsp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		s_tready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.phase  = bcsp_pkg::PH_SPT;
		cmd.finish = 1'b0;
		case (state_q)
			bcsp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = bcsp_pkg::ST_DIV_SPT;
				end
			end
			bcsp_pkg::ST_DIV_SPT: begin
				if (status.rej) begin
					state_nxt = bcsp_pkg::ST_FINISH;
				end else begin
					cmd.step = 1'b1;
					if (status.last) state_nxt = bcsp_pkg::ST_DIV_TRK;
				end
			end
			bcsp_pkg::ST_DIV_TRK: begin
				cmd.step  = 1'b1;
				cmd.phase = bcsp_pkg::PH_TRK;
				if (status.last) state_nxt = bcsp_pkg::ST_DIV_CYL;
			end
			bcsp_pkg::ST_DIV_CYL: begin
				cmd.step  = 1'b1;
				cmd.phase = bcsp_pkg::PH_CYL;
				if (status.last) state_nxt = bcsp_pkg::ST_FINISH;
			end
			bcsp_pkg::ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = bcsp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = bcsp_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == bcsp_pkg::ST_DIV_SPT)
		else $error("accepted transaction did not start the divider");

	a_rej_skips_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bcsp_pkg::ST_DIV_SPT && status.rej |-> !cmd.step)
		else $error("divider stepped on a rejected block");

	a_cyl_done_finish: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bcsp_pkg::ST_DIV_CYL && status.last |=> state_q == bcsp_pkg::ST_FINISH)
		else $error("last division did not lead to result hand-off");
`endif

endmodule

[hw/rtl/bcsp_dp.sv]
// Datapath of the seek planner: shared restoring divider, current cylinder,
// seek math and output register. Depends on bcsp_pkg.
module bcsp_dp #(
	parameter int BLOCK_WIDTH    = 16,
	parameter int CYLINDER_WIDTH = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bcsp_pkg::bcsp_cmd_t                 cmd,
	output bcsp_pkg::bcsp_status_t              status,
	input  logic [bcsp_pkg::BLOCK_W-1:0]        block_in,
	input  logic [bcsp_pkg::SPT_W-1:0]          spt,
	input  logic [bcsp_pkg::HEADS_W-1:0]        heads,
	input  logic [bcsp_pkg::LAST_W-1:0]         last_blk,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [bcsp_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                m_tuser
);

	localparam int CNTW = $clog2(BLOCK_WIDTH);
	localparam int DVW  = bcsp_pkg::SPT_W;

	logic [BLOCK_WIDTH-1:0]       dvd_q, dvd_new, blk;
	logic [DVW-1:0]               rem_q, rem_new, dvs_q;
	logic [DVW:0]                 rem_sh, rem_sub;
	logic                         ge;
	logic [CNTW-1:0]              cnt_q;
	logic [bcsp_pkg::SPT_W-1:0]   sector_q;
	logic [bcsp_pkg::HEAD_W-1:0]  head_q;
	logic                         rej_q, rej_now;
	logic [CYLINDER_WIDTH-1:0]    cur_q, cyl, steps;
	logic                         outward;
	logic [bcsp_pkg::OUT_DATA_W-1:0] tdata_q, tdata_new;
	logic                         tuser_q, valid_q;

	// one quotient bit per cycle while cmd.step is high
	assign rem_sh  = {rem_q, dvd_q[BLOCK_WIDTH-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_new = ge ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
	assign dvd_new = {dvd_q[BLOCK_WIDTH-2:0], ge};

	assign blk     = BLOCK_WIDTH'(block_in);
	assign rej_now = (32'(blk) > 32'(last_blk)) || (spt == '0) || (heads == '0);

	// seek from the remembered cylinder
	assign cyl     = CYLINDER_WIDTH'(dvd_q);
	assign outward = !(cur_q < cyl);
	assign steps   = outward ? (cur_q - cyl) : (cyl - cur_q);
	assign tdata_new = {5'b0, ~head_q, 2'b00, outward,
		bcsp_pkg::CYL_OUT_W'(steps), sector_q, head_q, bcsp_pkg::CYL_OUT_W'(cyl)};

	assign status.last     = cnt_q == CNTW'(BLOCK_WIDTH - 1);
	assign status.rej      = rej_q;
	assign status.out_free = !valid_q || m_tready;

	assign m_tvalid = valid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q <= blk;
			dvs_q <= spt;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.step) begin
			dvd_q <= dvd_new;
			if (status.last) begin
				rem_q <= '0;
				cnt_q <= '0;
				case (cmd.phase)
					bcsp_pkg::PH_SPT: begin
						sector_q <= rem_new;
						dvs_q    <= DVW'(heads);
					end
					bcsp_pkg::PH_CYL: begin
						head_q <= bcsp_pkg::HEAD_W'(rem_new);
					end
					default: begin
					end
				endcase
			end else begin
				rem_q <= rem_new;
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (cmd.finish) begin
			tdata_q <= rej_q ? '0 : tdata_new;
			tuser_q <= !rej_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rej_q   <= 1'b0;
			cur_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.load) rej_q <= rej_now;
			if (cmd.finish) begin
				valid_q <= 1'b1;
				if (!rej_q) cur_q <= cyl;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!valid_q || m_tready))
		else $error("result register overwritten before it was taken");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> dvs_q != '0)
		else $error("divider stepped with a zero divisor");

	a_rej_keeps_cyl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && rej_q |=> $stable(cur_q) && m_tdata == '0 && !m_tuser)
		else $error("rejected block changed state or gave nonzero fields");
`endif

endmodule
